[rtl/sctiu_pkg.sv]
`default_nettype none
package sctiu_pkg;

  localparam int NUM_TIMERS    = 3;
  localparam int NUM_SOURCES   = 11;
  localparam int TOP_LEVEL_SRC = 7;

  // Pending bit positions.
  localparam int SOFT_BIT        = 5;
  localparam int TIMER_BIT_BASE  = 6;
  localparam int SAMPLE_DONE_BIT = 10;

  typedef logic [NUM_SOURCES-1:0] pend_t;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_TIMER_WRITE = 3'd1,
    ACT_SOUND_SET   = 3'd2,
    ACT_SOUND_CLEAR = 3'd3,
    ACT_MAIN_SET    = 3'd4,
    ACT_MAIN_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    CFG_SOUND_ENABLE = 3'd0,
    CFG_MAIN_ENABLE  = 3'd1,
    CFG_LEVEL_BIT0   = 3'd2,
    CFG_LEVEL_BIT1   = 3'd3,
    CFG_LEVEL_BIT2   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    pend_t      sound_pending;
    logic [2:0] sound_level;
    logic       main_request;
  } result_t;

endpackage
`default_nettype wire

[rtl/sound_chip_timer_interrupt_unit.sv]
// Three prescaled 8-bit timers feeding a sound-side and a main-side interrupt
// pending set. Each input beat carries an action (tick, timer write, set or
// clear of a pending set) and produces exactly one result beat: the enabled
// sound-side pending bits, the level of the lowest-numbered one, and the
// main-side request line, all as they stand after the action.
// The state update and the result are computed in the cycle of acceptance,
// and the result is registered into the output buffer; the block accepts one
// beat per cycle while in_ready is high, set by the single state update path.
// A two-entry output buffer (result register plus skid register) lets the
// block take a new beat while a finished result waits; in_ready drops only
// when both entries are full, and results leave in order.
// The configuration port writes enable masks and level selects; it must only
// be used while no beat is in flight.
// A synchronous reset clears configuration, timers (prescalers to one),
// both pending sets and the output buffer.
`default_nettype none
module sound_chip_timer_interrupt_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               action,
  input  wire logic [1:0]               timer_select,
  input  wire logic [15:0]              write_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output sctiu_pkg::pend_t              sound_pending,
  output logic [2:0]                    sound_level,
  output logic                          main_request,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [10:0]              cfg_data
);
  import sctiu_pkg::*;

  pend_t      sound_enable_mask;
  pend_t      main_enable_mask;
  logic [7:0] level_bit0_select;
  logic [7:0] level_bit1_select;
  logic [7:0] level_bit2_select;

  logic [7:0] timer_count [NUM_TIMERS];
  logic [7:0] prescale_reload [NUM_TIMERS];
  logic [7:0] prescale_left [NUM_TIMERS];
  pend_t      sound_pending_bits;
  pend_t      main_pending_bits;

  logic [7:0] timer_count_next [NUM_TIMERS];
  logic [7:0] prescale_reload_next [NUM_TIMERS];
  logic [7:0] prescale_left_next [NUM_TIMERS];
  pend_t      sound_pending_bits_next;
  pend_t      main_pending_bits_next;

  result_t    res;
  result_t    out_data;
  result_t    skid_data;
  logic       skid_valid;
  logic       push;
  logic       pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Next state for one action.
  always_comb begin
    logic [7:0] left_dec;
    logic [7:0] count_inc;
    logic [7:0] step;
    pend_t      timer_wrap;
    timer_wrap = '0;
    step       = 8'(1) << write_data[10:8];
    sound_pending_bits_next = sound_pending_bits;
    main_pending_bits_next  = main_pending_bits;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      timer_count_next[t]     = timer_count[t];
      prescale_reload_next[t] = prescale_reload[t];
      prescale_left_next[t]   = prescale_left[t];
      left_dec  = prescale_left[t] - 8'd1;
      count_inc = timer_count[t] + 8'd1;
      case (action)
        ACT_TICK: begin
          if (left_dec == 8'd0) begin
            prescale_left_next[t] = prescale_reload[t];
            timer_count_next[t]   = count_inc;
            if (count_inc == 8'd0) begin
              timer_wrap[TIMER_BIT_BASE + t] = 1'b1;
            end
          end else begin
            prescale_left_next[t] = left_dec;
          end
        end
        ACT_TIMER_WRITE: begin
          if (timer_select == 2'(t)) begin
            timer_count_next[t] = write_data[7:0];
            // The prescaler restarts only when the division ratio changes.
            if (step != prescale_reload[t]) begin
              prescale_reload_next[t] = step;
              prescale_left_next[t]   = step;
            end
          end
        end
        default: begin
        end
      endcase
    end
    case (action)
      ACT_TICK: begin
        sound_pending_bits_next = sound_pending_bits | timer_wrap;
        sound_pending_bits_next[SAMPLE_DONE_BIT] = 1'b1;
        main_pending_bits_next  = main_pending_bits | timer_wrap;
      end
      ACT_SOUND_SET: begin
        if (write_data[SOFT_BIT]) begin
          sound_pending_bits_next[SOFT_BIT] = 1'b1;
        end
      end
      ACT_SOUND_CLEAR: begin
        sound_pending_bits_next = sound_pending_bits & ~write_data[NUM_SOURCES-1:0];
      end
      ACT_MAIN_SET: begin
        if (write_data[SOFT_BIT]) begin
          main_pending_bits_next[SOFT_BIT] = 1'b1;
        end
      end
      ACT_MAIN_CLEAR: begin
        main_pending_bits_next = main_pending_bits & ~write_data[NUM_SOURCES-1:0];
      end
      default: begin
      end
    endcase
  end

  // Result from the updated state. Sources above seven share seven's level.
  always_comb begin
    pend_t      active;
    logic [2:0] src;
    active = sound_enable_mask & sound_pending_bits_next;
    src    = 3'd0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (active[i]) begin
        src = (i > TOP_LEVEL_SRC) ? 3'(TOP_LEVEL_SRC) : 3'(i);
      end
    end
    res.sound_pending = active;
    res.sound_level   = (active == '0) ? 3'd0 :
                        {level_bit2_select[src], level_bit1_select[src],
                         level_bit0_select[src]};
    res.main_request  = |(main_enable_mask & main_pending_bits_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable_mask  <= '0;
      main_enable_mask   <= '0;
      level_bit0_select  <= '0;
      level_bit1_select  <= '0;
      level_bit2_select  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOUND_ENABLE: sound_enable_mask <= cfg_data;
        CFG_MAIN_ENABLE:  main_enable_mask  <= cfg_data;
        CFG_LEVEL_BIT0:   level_bit0_select <= cfg_data[7:0];
        CFG_LEVEL_BIT1:   level_bit1_select <= cfg_data[7:0];
        CFG_LEVEL_BIT2:   level_bit2_select <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        timer_count[t]     <= '0;
        prescale_reload[t] <= 8'd1;
        prescale_left[t]   <= 8'd1;
      end
      sound_pending_bits <= '0;
      main_pending_bits  <= '0;
    end else if (push) begin
      timer_count        <= timer_count_next;
      prescale_reload    <= prescale_reload_next;
      prescale_left      <= prescale_left_next;
      sound_pending_bits <= sound_pending_bits_next;
      main_pending_bits  <= main_pending_bits_next;
    end
  end

  // Two-entry output buffer: out_data is the head, skid_data the overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= res;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end
  end

  assign sound_pending = out_data.sound_pending;
  assign sound_level   = out_data.sound_level;
  assign main_request  = out_data.main_request;

endmodule
`default_nettype wire

[tb/timer_irq_checker.sv]
`timescale 1ns / 100ps
module timer_irq_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        action,
  input  logic [1:0]        timer_select,
  input  logic [15:0]       write_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  sctiu_pkg::pend_t  sound_pending,
  input  logic [2:0]        sound_level,
  input  logic              main_request,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  output int                fail_count,
  output int                results_waiting,
  output int                results_checked,
  output int                wrap_count
);
  import sctiu_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [7:0] count_q  [NUM_TIMERS];
  logic [2:0] mode_q   [NUM_TIMERS];
  logic [7:0] reload_q [NUM_TIMERS];
  logic [7:0] left_q   [NUM_TIMERS];
  pend_t      sound_bits, main_bits;
  pend_t      sound_en, main_en;
  logic [7:0] level_sel0, level_sel1, level_sel2;

  result_t expected_irq_results [$];
  int      errors = 0;
  int      checked = 0;
  int      wraps = 0;

  // Sources above the top level source share its level bits.
  function automatic logic [2:0] source_level(int src);
    int s;
    s = (src > TOP_LEVEL_SRC) ? TOP_LEVEL_SRC : src;
    return {level_sel2[s], level_sel1[s], level_sel0[s]};
  endfunction

  // Applies one beat to the shadow state and returns the result it causes.
  function automatic result_t predict_irq_result(logic [2:0] act, logic [1:0] sel,
                                                 logic [15:0] data);
    logic [2:0] mode;
    logic [7:0] prescale;
    pend_t      active;
    result_t    res;
    case (act)
      ACT_TICK: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          left_q[t] = left_q[t] - 8'd1;
          if (left_q[t] == 8'd0) begin
            left_q[t] = reload_q[t];
            count_q[t] = count_q[t] + 8'd1;
            if (count_q[t] == 8'd0) begin
              sound_bits[TIMER_BIT_BASE + t] = 1'b1;
              main_bits[TIMER_BIT_BASE + t] = 1'b1;
              wraps++;
            end
          end
        end
        sound_bits[SAMPLE_DONE_BIT] = 1'b1;
      end
      ACT_TIMER_WRITE: begin
        if (sel < NUM_TIMERS) begin
          mode = data[10:8];
          prescale = 8'd1 << mode;
          count_q[sel] = data[7:0];
          mode_q[sel] = mode;
          // The prescaler restarts only when the division ratio changes.
          if (prescale != reload_q[sel]) begin
            reload_q[sel] = prescale;
            left_q[sel] = prescale;
          end
        end
      end
      ACT_SOUND_SET: begin
        if (data[SOFT_BIT]) sound_bits[SOFT_BIT] = 1'b1;
      end
      ACT_SOUND_CLEAR: sound_bits = sound_bits & ~data[NUM_SOURCES-1:0];
      ACT_MAIN_SET: begin
        if (data[SOFT_BIT]) main_bits[SOFT_BIT] = 1'b1;
      end
      ACT_MAIN_CLEAR: main_bits = main_bits & ~data[NUM_SOURCES-1:0];
      default: ;
    endcase
    active = sound_en & sound_bits;
    res.sound_pending = active;
    res.sound_level = 3'd0;
    res.main_request = |(main_en & main_bits);
    // Walk downward so the lowest-numbered active source wins.
    for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
      if (active[s]) res.sound_level = source_level(s);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_q[t] = 8'd0;
        mode_q[t] = 3'd0;
        reload_q[t] = 8'd1;
        left_q[t] = 8'd1;
      end
      sound_bits = '0;
      main_bits = '0;
      sound_en = '0;
      main_en = '0;
      level_sel0 = 8'd0;
      level_sel1 = 8'd0;
      level_sel2 = 8'd0;
      expected_irq_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOUND_ENABLE: sound_en = cfg_data;
          CFG_MAIN_ENABLE:  main_en = cfg_data;
          CFG_LEVEL_BIT0:   level_sel0 = cfg_data[7:0];
          CFG_LEVEL_BIT1:   level_sel1 = cfg_data[7:0];
          CFG_LEVEL_BIT2:   level_sel2 = cfg_data[7:0];
          default: ;
        endcase
      end
      // Drain before fill, so a result that leaves in the same cycle as its input is flagged.
      if (out_valid && out_ready) begin
        if (expected_irq_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result beat: pending %03h level %0d request %0b",
                     sound_pending, sound_level, main_request);
        end else begin
          want = expected_irq_results.pop_front();
          checked++;
          if (want.sound_pending !== sound_pending || want.sound_level !== sound_level ||
              want.main_request !== main_request) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("result %0d: expected pending %03h level %0d request %0b, got %03h %0d %0b",
                       checked, want.sound_pending, want.sound_level, want.main_request,
                       sound_pending, sound_level, main_request);
          end
        end
      end
      if (in_valid && in_ready)
        expected_irq_results.push_back(predict_irq_result(action, timer_select, write_data));
    end
    fail_count <= errors;
    results_waiting <= expected_irq_results.size();
    results_checked <= checked;
    wrap_count <= wraps;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
  import sctiu_pkg::*;

  localparam int         SETTINGS_RUN      = 6;
  localparam int         BEATS_PER_SETTING = 325;
  localparam int         CYCLE_LIMIT       = 200000;
  localparam logic [2:0] ACT_SPARE_LO      = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI      = 3'd7;
  localparam logic [2:0] CFG_NO_REG        = 3'd7;
  localparam logic [1:0] NO_TIMER          = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [2:0]  action = ACT_TICK;
  logic [1:0]  timer_select = 2'd0;
  logic [15:0] write_data = 16'h0000;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_SOUND_ENABLE;
  logic [10:0] cfg_data = 11'h000;

  logic        in_ready;
  logic        out_valid;
  pend_t       sound_pending;
  logic [2:0]  sound_level;
  logic        main_request;

  int fail_count, results_waiting, results_checked, wrap_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent = 0;

  sound_chip_timer_interrupt_unit dut (.*);
  timer_irq_checker checker_i (.*);

  always #2 clk = ~clk;

  always @(posedge clk) out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);

  // Leaves valid high on return; the next call or the caller decides whether it drops.
  task automatic push_beat(input logic [2:0] act, input logic [1:0] sel,
                           input logic [15:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    timer_select <= sel;
    write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  initial begin
    logic [10:0] snd_mask, main_mask, lvl0, lvl1, lvl2;
    logic [2:0]  act;
    logic [1:0]  sel;
    logic [15:0] data;
    int          pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < SETTINGS_RUN; n++) begin
      // Registers change only once the block has drained.
      in_valid <= 1'b0;
      @(posedge clk);
      while (results_waiting != 0) @(posedge clk);
      repeat (3) @(posedge clk);

      case (n)
        0: begin
          // Level of source s is s itself, so the priority pick is visible.
          snd_mask = 11'h7FF; main_mask = 11'h7FF;
          lvl0 = 11'h0AA; lvl1 = 11'h0CC; lvl2 = 11'h0F0;
        end
        1: begin
          snd_mask = 11'h000; main_mask = 11'h000;
          lvl0 = 11'h000; lvl1 = 11'h000; lvl2 = 11'h000;
        end
        2: begin
          snd_mask = 11'h7FF; main_mask = 11'h7FF;
          lvl0 = 11'h7FF; lvl1 = 11'h7FF; lvl2 = 11'h7FF;
        end
        default: begin
          snd_mask = 11'($urandom_range(0, 2047));
          main_mask = 11'($urandom_range(0, 2047));
          lvl0 = 11'($urandom_range(0, 2047));
          lvl1 = 11'($urandom_range(0, 2047));
          lvl2 = 11'($urandom_range(0, 2047));
        end
      endcase
      write_reg(CFG_SOUND_ENABLE, snd_mask);
      write_reg(CFG_MAIN_ENABLE, main_mask);
      write_reg(CFG_LEVEL_BIT0, lvl0);
      write_reg(CFG_LEVEL_BIT1, lvl1);
      write_reg(CFG_LEVEL_BIT2, lvl2);
      // A write past the last register must leave the all-ones setting alone.
      if (n == 2) write_reg(CFG_NO_REG, 11'h000);
      cfg_we <= 1'b0;

      if (n < 2) begin
        send_idle_pct = 17; recv_idle_pct = 78;
      end else if (n < 4) begin
        send_idle_pct = 78; recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end

      if (n == 0) begin
        push_beat(ACT_TICK, 2'd0, 16'h0000);
        push_beat(ACT_TIMER_WRITE, 2'd0, 16'h00FF);
        push_beat(ACT_TICK, 2'd1, 16'hFFFF);           // timer 0 wraps
        push_beat(ACT_TIMER_WRITE, 2'd1, 16'hFFFF);    // slowest prescaler, high bits set
        push_beat(ACT_TIMER_WRITE, 2'd1, 16'h07FE);    // same ratio, prescaler keeps going
        push_beat(ACT_TIMER_WRITE, NO_TIMER, 16'hFFFF);
        push_beat(ACT_SOUND_SET, 2'd0, 16'h0020);
        push_beat(ACT_MAIN_SET, 2'd2, 16'hFFDF);
        push_beat(ACT_MAIN_SET, 2'd0, 16'h0020);
        push_beat(ACT_SOUND_CLEAR, 2'd3, 16'hF800);
        push_beat(ACT_SOUND_CLEAR, 2'd0, 16'h0040);
        push_beat(ACT_MAIN_CLEAR, 2'd0, 16'hFFFF);
        push_beat(ACT_SPARE_LO, NO_TIMER, 16'hFFFF);
        push_beat(ACT_SPARE_HI, 2'd0, 16'h0000);
        push_beat(ACT_TIMER_WRITE, 2'd2, 16'h01FF);
        push_beat(ACT_TICK, 2'd0, 16'h0000);
        push_beat(ACT_TICK, 2'd0, 16'h0000);           // timer 2 wraps
        push_beat(ACT_SOUND_CLEAR, 2'd0, 16'h07FF);
        push_beat(ACT_TICK, 2'd2, 16'h5555);
        push_beat(ACT_MAIN_SET, 2'd0, 16'h0000);
        push_beat(ACT_SOUND_SET, 2'd3, 16'hFFFF);
        push_beat(ACT_TIMER_WRITE, 2'd0, 16'h0000);
        push_beat(ACT_MAIN_CLEAR, 2'd1, 16'h0000);
      end

      for (int i = 0; i < BEATS_PER_SETTING; i++) begin
        pick = $urandom_range(0, 99);
        sel = 2'($urandom_range(0, 3));
        data = 16'($urandom);
        if (pick < 45) begin
          act = ACT_TICK;
        end else if (pick < 62) begin
          act = ACT_TIMER_WRITE;
          // Mostly counts close to the top with short prescalers, so wraps are frequent.
          if ($urandom_range(0, 3) != 0) begin
            sel = ($urandom_range(0, 9) == 0) ? NO_TIMER : 2'($urandom_range(0, 2));
            data[10:0] = {3'($urandom_range(0, 2)), 8'($urandom_range(248, 255))};
          end
        end else if (pick < 70) begin
          act = ACT_SOUND_SET;
        end else if (pick < 78) begin
          act = ACT_SOUND_CLEAR;
        end else if (pick < 86) begin
          act = ACT_MAIN_SET;
        end else if (pick < 94) begin
          act = ACT_MAIN_CLEAR;
        end else begin
          act = pick[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
        end
        push_beat(act, sel, data);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("%0d beats under %0d mask and level settings, with sender and receiver stalls",
             beats_sent, SETTINGS_RUN);
    $display("%0d results compared, %0d counter wraps predicted",
             results_checked, wrap_count);
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

endmodule
